// ===== hw/rtl/lsnf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lsnf_pkg
// types and codes shared by the link-state neighbor state machine
// ----------------------------------------------------------------------------
package lsnf_pkg;

  localparam int unsigned ID_W     = 32;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned STATE_W  = 3;
  localparam int unsigned LINK_W   = 3;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OWN_ROUTER_ID = 1'b0,
    REG_LINK_TYPE     = 1'b1
  } cfg_reg_t;

  typedef enum logic [LINK_W-1:0] {
    LINK_BROADCAST = 3'd0,
    LINK_NBMA      = 3'd1,
    LINK_P2P       = 3'd2,
    LINK_P2MP      = 3'd3,
    LINK_VIRTUAL   = 3'd4
  } link_t;

  typedef enum logic [MODE_W-1:0] {
    EV_HELLO        = 3'd0,
    EV_ONE_WAY      = 3'd1,
    EV_TWO_WAY      = 3'd2,
    EV_NEGOTIATED   = 3'd3,
    EV_SEQ_MISMATCH = 3'd4,
    EV_EXCHANGED    = 3'd5,
    EV_BAD_REQUEST  = 3'd6,
    EV_LOADED       = 3'd7
  } event_code_t;

  typedef enum logic [STATE_W-1:0] {
    ST_DOWN     = 3'd0,
    ST_INIT     = 3'd1,
    ST_TWO_WAY  = 3'd2,
    ST_EXSTART  = 3'd3,
    ST_EXCHANGE = 3'd4,
    ST_LOADING  = 3'd5,
    ST_FULL     = 3'd6
  } adj_state_t;

  typedef struct packed {
    event_code_t     mode;
    logic [ID_W-1:0] neighbor_id;
    logic [ID_W-1:0] neighbor_dr;
    logic [ID_W-1:0] neighbor_bdr;
    logic            request_list_empty;
    logic            interface_dr_is_self;
  } event_t;

  typedef struct packed {
    logic [STATE_W-1:0] new_state;
    logic               accepted;
    logic               start_empty_dd;
    logic               build_summary;
    logic               gen_router_lsa;
    logic               gen_network_lsa;
    logic               flood_database;
    logic               start_request_send;
    logic               update_routes;
    logic               master_role;
  } result_t;

  typedef struct packed {
    logic [ID_W-1:0] own_router_id;
    link_t           link_type;
  } cfg_t;

endpackage
`default_nettype wire

// ===== hw/rtl/lsnf_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lsnf_if
// valid/ready channels for neighbor events and adjacency results
// ----------------------------------------------------------------------------
interface lsnf_event_if;
  import lsnf_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [ID_W-1:0]   neighbor_id;
  logic [ID_W-1:0]   neighbor_dr;
  logic [ID_W-1:0]   neighbor_bdr;
  logic              request_list_empty;
  logic              interface_dr_is_self;

  modport source (
    output valid, mode, neighbor_id, neighbor_dr, neighbor_bdr,
           request_list_empty, interface_dr_is_self,
    input  ready
  );

  modport sink (
    input  valid, mode, neighbor_id, neighbor_dr, neighbor_bdr,
           request_list_empty, interface_dr_is_self,
    output ready
  );
endinterface

interface lsnf_result_if;
  import lsnf_pkg::*;

  logic               valid;
  logic               ready;
  logic [STATE_W-1:0] new_state;
  logic               accepted;
  logic               start_empty_dd;
  logic               build_summary;
  logic               gen_router_lsa;
  logic               gen_network_lsa;
  logic               flood_database;
  logic               start_request_send;
  logic               update_routes;
  logic               master_role;

  modport source (
    output valid, new_state, accepted, start_empty_dd, build_summary,
           gen_router_lsa, gen_network_lsa, flood_database,
           start_request_send, update_routes, master_role,
    input  ready
  );

  modport sink (
    input  valid, new_state, accepted, start_empty_dd, build_summary,
           gen_router_lsa, gen_network_lsa, flood_database,
           start_request_send, update_routes, master_role,
    output ready
  );
endinterface
`default_nettype wire

// ===== hw/rtl/lsnf_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lsnf_step
// next adjacency state, master flag and action strobes for one event
// ----------------------------------------------------------------------------
module lsnf_step
  import lsnf_pkg::*;
(
  input  adj_state_t state,
  input  logic       master,
  input  cfg_t       cfg,
  input  event_t     ev,
  output adj_state_t state_next,
  output logic       master_next,
  output result_t    res
);

  logic multi_access;
  logic no_dr;

  assign multi_access = (cfg.link_type == LINK_BROADCAST) || (cfg.link_type == LINK_NBMA);
  assign no_dr = (ev.neighbor_id != ev.neighbor_dr) && (ev.neighbor_id != ev.neighbor_bdr) &&
                 (cfg.own_router_id != ev.neighbor_dr) &&
                 (cfg.own_router_id != ev.neighbor_bdr);

  always_comb begin
    state_next  = state;
    master_next = master;
    res         = '0;
    unique case (ev.mode)
      EV_HELLO: begin
        res.accepted = 1'b1;
        if (state == ST_DOWN) begin
          state_next = ST_INIT;
        end
      end
      EV_ONE_WAY: begin
        if (state >= ST_TWO_WAY) begin
          res.accepted = 1'b1;
          state_next   = ST_INIT;
        end
      end
      EV_TWO_WAY: begin
        if (state == ST_INIT) begin
          res.accepted = 1'b1;
          if (multi_access && no_dr) begin
            state_next = ST_TWO_WAY;
          end else begin
            state_next         = ST_EXSTART;
            master_next        = 1'b1;
            res.start_empty_dd = 1'b1;
          end
        end
      end
      EV_NEGOTIATED: begin
        if (state == ST_EXSTART) begin
          res.accepted      = 1'b1;
          res.build_summary = 1'b1;
          state_next        = ST_EXCHANGE;
        end
      end
      EV_SEQ_MISMATCH, EV_BAD_REQUEST: begin
        if (state >= ST_EXCHANGE) begin
          res.accepted = 1'b1;
          state_next   = ST_EXSTART;
        end
      end
      EV_EXCHANGED: begin
        if (state == ST_EXCHANGE) begin
          res.accepted = 1'b1;
          if (ev.request_list_empty) begin
            state_next          = ST_FULL;
            res.gen_router_lsa  = 1'b1;
            res.gen_network_lsa = ev.interface_dr_is_self;
            res.flood_database  = 1'b1;
          end else begin
            state_next             = ST_LOADING;
            res.start_request_send = 1'b1;
          end
        end
      end
      EV_LOADED: begin
        if (state == ST_LOADING) begin
          res.accepted       = 1'b1;
          state_next         = ST_FULL;
          res.gen_router_lsa = 1'b1;
          res.flood_database = 1'b1;
          res.update_routes  = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.new_state   = state_next;
    res.master_role = master_next;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/link_state_neighbor_fsm.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// link_state_neighbor_fsm
// adjacency state machine for one link-state routing neighbor
// ----------------------------------------------------------------------------
// path: an accepted request passes the event register, then the result
//   register; the event register holds while a result waits for res.ready
// throughput: 1 request per cycle while res.ready stays high; the state
//   update is a single pass of compare and select logic between the two registers
// reset: state down, master flag clear, config registers zero
// ----------------------------------------------------------------------------
module link_state_neighbor_fsm
  import lsnf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  lsnf_event_if.sink            evt,
  lsnf_result_if.source         res
);

  cfg_t       cfg;
  adj_state_t state;
  logic       master;
  logic       ev_valid;
  event_t     ev_q;
  logic       res_valid;
  result_t    res_q;

  adj_state_t state_next;
  logic       master_next;
  result_t    step_res;
  logic       load_res;
  logic       take_evt;

  assign load_res = ev_valid && (!res_valid || res.ready);
  assign evt.ready = !ev_valid || load_res;
  assign take_evt = evt.valid && evt.ready;

  lsnf_step u_step (
    .state       (state),
    .master      (master),
    .cfg         (cfg),
    .ev          (ev_q),
    .state_next  (state_next),
    .master_next (master_next),
    .res         (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg       <= '{own_router_id: '0, link_type: LINK_BROADCAST};
      state     <= ST_DOWN;
      master    <= 1'b0;
      ev_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_OWN_ROUTER_ID: cfg.own_router_id <= cfg_data[ID_W-1:0];
          REG_LINK_TYPE:     cfg.link_type     <= link_t'(cfg_data[LINK_W-1:0]);
          default: begin
          end
        endcase
      end
      if (take_evt) begin
        ev_valid <= 1'b1;
      end else if (load_res) begin
        ev_valid <= 1'b0;
      end
      if (load_res) begin
        res_valid <= 1'b1;
        state     <= state_next;
        master    <= master_next;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_evt) begin
      ev_q.mode                 <= event_code_t'(evt.mode);
      ev_q.neighbor_id          <= evt.neighbor_id;
      ev_q.neighbor_dr          <= evt.neighbor_dr;
      ev_q.neighbor_bdr         <= evt.neighbor_bdr;
      ev_q.request_list_empty   <= evt.request_list_empty;
      ev_q.interface_dr_is_self <= evt.interface_dr_is_self;
    end
    if (load_res) begin
      res_q <= step_res;
    end
  end

  assign res.valid              = res_valid;
  assign res.new_state          = res_q.new_state;
  assign res.accepted           = res_q.accepted;
  assign res.start_empty_dd     = res_q.start_empty_dd;
  assign res.build_summary      = res_q.build_summary;
  assign res.gen_router_lsa     = res_q.gen_router_lsa;
  assign res.gen_network_lsa    = res_q.gen_network_lsa;
  assign res.flood_database     = res_q.flood_database;
  assign res.start_request_send = res_q.start_request_send;
  assign res.update_routes      = res_q.update_routes;
  assign res.master_role        = res_q.master_role;

  a_master_sticky: assert property (@(posedge clk) disable iff (rst)
    master |=> master)
    else $error("master flag cleared outside reset");

  a_reject_quiet: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_q.accepted) |->
      (res_q.start_empty_dd == 1'b0 && res_q.build_summary == 1'b0 &&
       res_q.gen_router_lsa == 1'b0 && res_q.gen_network_lsa == 1'b0 &&
       res_q.flood_database == 1'b0 && res_q.start_request_send == 1'b0 &&
       res_q.update_routes == 1'b0))
    else $error("strobe raised on a rejected event");

  a_state_matches_result: assert property (@(posedge clk) disable iff (rst)
    load_res |=> (res_q.new_state == state && res_q.master_role == master))
    else $error("result does not match stored adjacency state");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.ready) |=> (res_valid && $stable(res_q)))
    else $error("pending result overwritten");

endmodule
`default_nettype wire
